// ----- rtl/lpd_pkg.sv -----
`default_nettype none

package lpd_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned LEN_W      = 31;

  localparam logic [0:0] REG_MAX_UNAUTH_LENGTH = 1'b0;
  localparam logic [LEN_W-1:0] MAX_UNAUTH_LENGTH_RST = 31'd1024;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  localparam logic [1:0] RES_PAYLOAD  = 2'd0;
  localparam logic [1:0] RES_OVERSIZE = 2'd1;
  localparam logic [1:0] RES_SYNC     = 2'd2;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       authorized;
  } item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] payload_byte;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/lpd_in_if.sv -----
`default_nettype none

interface lpd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic       authorized;

  modport source (output valid, output kind, output data_byte, output authorized,
                  input ready);
  modport sink (input valid, input kind, input data_byte, input authorized,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/lpd_out_if.sv -----
`default_nettype none

interface lpd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] payload_byte;
  logic       last;

  modport source (output valid, output result_kind, output payload_byte, output last,
                  input ready);
  modport sink (input valid, input result_kind, input payload_byte, input last,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/lpd_cfg.sv -----
`default_nettype none

module lpd_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [lpd_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [lpd_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [lpd_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                    pready,
  output logic      [lpd_pkg::LEN_W-1:0]          max_len
);

  logic [lpd_pkg::LEN_W-1:0] max_len_r;
  logic                      reg_hit;

  assign reg_hit = (paddr[lpd_pkg::CFG_ADDR_W-1 -: 1] == lpd_pkg::REG_MAX_UNAUTH_LENGTH);
  assign pready  = 1'b1;
  assign max_len = max_len_r;
  assign prdata  = reg_hit ? {1'b0, max_len_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= lpd_pkg::MAX_UNAUTH_LENGTH_RST;
    end else if (psel && penable && pwrite && reg_hit) begin
      max_len_r <= pwdata[lpd_pkg::LEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lpd_core.sv -----
`default_nettype none

module lpd_core #(
  parameter int PREFIX_BYTES = 4
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire lpd_pkg::item_t            in_item,
  input  wire logic [lpd_pkg::LEN_W-1:0] max_len,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output lpd_pkg::res_t                  out_res
);

  localparam logic [2:0] LAST_CNT = 3'(PREFIX_BYTES - 1);

  lpd_pkg::item_t            item_r;
  logic                      item_v_r;
  lpd_pkg::res_t             out_r, res_nxt;
  logic                      out_v_r;

  logic [23:0]               shift_r, shift_nxt;
  logic [2:0]                pcnt_r, pcnt_nxt;
  logic [lpd_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [lpd_pkg::LEN_W-1:0] cnt_r, cnt_nxt;
  logic                      closed_r, closed_nxt;

  logic                      adv, proc, emit;
  logic [31:0]               full;
  logic                      negative;

  assign adv       = !out_v_r || out_ready;
  assign proc      = item_v_r && adv;
  assign in_ready  = !item_v_r || adv;
  assign out_valid = out_v_r;
  assign out_res   = out_r;
  assign full      = {shift_r, item_r.data_byte};
  assign negative  = full[31];

  always_comb begin
    shift_nxt  = shift_r;
    pcnt_nxt   = pcnt_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    closed_nxt = closed_r;
    emit       = 1'b0;
    res_nxt    = '{result_kind: lpd_pkg::RES_PAYLOAD, payload_byte: 8'h00, last: 1'b0};
    if (item_r.kind == lpd_pkg::KIND_RESTART) begin
      shift_nxt  = '0;
      pcnt_nxt   = '0;
      len_nxt    = '0;
      cnt_nxt    = '0;
      closed_nxt = 1'b0;
    end else if (!closed_r) begin
      if (len_r != '0) begin
        cnt_nxt              = cnt_r + 1'b1;
        emit                 = 1'b1;
        res_nxt.payload_byte = item_r.data_byte;
        if (cnt_nxt >= len_r) begin
          res_nxt.last = 1'b1;
          len_nxt      = '0;
          cnt_nxt      = '0;
        end
      end else if (pcnt_r != LAST_CNT) begin
        shift_nxt = {shift_r[15:0], item_r.data_byte};
        pcnt_nxt  = pcnt_r + 1'b1;
      end else begin
        shift_nxt = '0;
        pcnt_nxt  = '0;
        cnt_nxt   = '0;
        if (!item_r.authorized && !negative && (full > {1'b0, max_len})) begin
          closed_nxt          = 1'b1;
          len_nxt             = '0;
          emit                = 1'b1;
          res_nxt.result_kind = lpd_pkg::RES_OVERSIZE;
        end else if (negative) begin
          closed_nxt          = 1'b1;
          len_nxt             = '0;
          emit                = 1'b1;
          res_nxt.result_kind = lpd_pkg::RES_SYNC;
        end else begin
          len_nxt = full[lpd_pkg::LEN_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      shift_r  <= '0;
      pcnt_r   <= '0;
      len_r    <= '0;
      cnt_r    <= '0;
      closed_r <= 1'b0;
    end else begin
      if (in_ready) begin
        item_v_r <= in_valid;
      end
      if (adv) begin
        out_v_r <= proc && emit;
      end
      if (proc) begin
        shift_r  <= shift_nxt;
        pcnt_r   <= pcnt_nxt;
        len_r    <= len_nxt;
        cnt_r    <= cnt_nxt;
        closed_r <= closed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
    if (proc && emit) begin
      out_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/length_prefix_deframer.sv -----
// length-prefix deframer
// input channel in_bus: one beat per received byte (kind = data) or a restart
// beat (kind = restart) that clears the framing state. authorized is sampled
// on the beat that completes the big-endian length prefix.
// output channel out_bus: one beat per payload byte (last marks the end of a
// message), or one close beat for an oversize length or a sync error. prefix
// bytes, zero-length messages, restarts and bytes after a close give no beat.
// apb port: register 0 at address 0 holds max_unauth_length (reset 1024).
// a byte is registered in the input register on accept, and its result goes
// to the output register once that register is empty or being taken. throughput:
// one byte per cycle while the receiver does not stall; the framing update is a
// single pass of compare and count logic between the input and output registers.
// when the receiver stalls, the output register holds its beat, the input
// register holds one more byte, then in_bus.ready drops.
// reset (rst_n, synchronous, active low) empties both registers, clears the
// framing state and the closed flag, and loads the register's reset value.
`default_nettype none

module length_prefix_deframer #(
  parameter int PREFIX_BYTES = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  lpd_in_if.sink                                  in_bus,
  lpd_out_if.source                               out_bus,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [lpd_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [lpd_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [lpd_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                    pready
);

  logic [lpd_pkg::LEN_W-1:0] max_len;
  lpd_pkg::item_t            in_item;
  lpd_pkg::res_t             out_res;
  logic                      in_ready;
  logic                      out_valid;

  assign in_item = '{kind: in_bus.kind, data_byte: in_bus.data_byte,
                     authorized: in_bus.authorized};
  assign in_bus.ready         = in_ready;
  assign out_bus.valid        = out_valid;
  assign out_bus.result_kind  = out_res.result_kind;
  assign out_bus.payload_byte = out_res.payload_byte;
  assign out_bus.last         = out_res.last;

  lpd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_len (max_len)
  );

  lpd_core #(
    .PREFIX_BYTES (PREFIX_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .max_len   (max_len),
    .out_valid (out_valid),
    .out_ready (out_bus.ready),
    .out_res   (out_res)
  );

endmodule

`default_nettype wire
